>>> hdl/ups2x_pkg.sv
// ----------------------------------------------------------------------------
// ups2x_pkg
// Shared types, register map and channel arithmetic for the 2x averaging
// upscaler.
// ----------------------------------------------------------------------------
package ups2x_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;

  localparam int unsigned CFG_W     = 11;
  localparam int unsigned COORD_W   = 11;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned APB_AW    = 3;

  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(480);

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic [CHAN_W-1:0]  red_out;
    logic [CHAN_W-1:0]  green_out;
    logic [CHAN_W-1:0]  blue_out;
    logic               run_end;
  } pix_out_t;

  // Results still owed for the item in the work stage, in emission order.
  typedef struct packed {
    logic corner;
    logic vert;
    logic horiz;
    logic copy;
  } pend_t;

  function automatic logic [CHAN_W-1:0] avg_chan(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    logic [CHAN_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CHAN_W:1];
  endfunction

  function automatic rgb_t avg_rgb(input rgb_t a, input rgb_t b);
    rgb_t res;
    res.red   = avg_chan(a.red, b.red);
    res.green = avg_chan(a.green, b.green);
    res.blue  = avg_chan(a.blue, b.blue);
    return res;
  endfunction

endpackage

>>> hdl/upscale_2x_averaging_core.sv
// ----------------------------------------------------------------------------
// upscale_2x_averaging_core
// Streaming 2x upscaler: source pixel (r,c) lands at (2r,2c); the pixels in
// between are truncated means of their copied neighbors. Each source pixel
// produces one to four output pixels (four once both r and c are nonzero),
// and results leave one per cycle, while the output is not stalled, from a
// single output register, so a pixel occupies the work stage until it has
// handed off all its results; the next pixel is taken in the same cycle
// its predecessor hands off its last result. The previous source row sits
// in a MAX_WIDTH-entry memory read as a pixel enters the work stage; it
// needs no clearing after reset. A write to either dimension register
// restarts the frame at row 0, column 0.
// ----------------------------------------------------------------------------
module upscale_2x_averaging_core
  import ups2x_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,

  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pix_in_t           in_data_i,

  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pix_out_t          out_data_o
);

  localparam int unsigned CW  = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1;
  localparam int unsigned RW  = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned CWW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int unsigned RWW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

  // Configuration registers
  logic [CFG_W-1:0] width_q, height_q;
  logic             cfg_wr;
  reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_comb begin
    unique case (cfg_idx)
      REG_IMAGE_WIDTH:  prdata = APB_DW'(width_q);
      REG_IMAGE_HEIGHT: prdata = APB_DW'(height_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_IMAGE_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped dimensions
  logic [CWW-1:0] w_ext, w_clamp;
  logic [RWW-1:0] h_ext, h_clamp;

  assign w_ext = CWW'(width_q);
  assign h_ext = RWW'(height_q);

  always_comb begin
    priority if (w_ext < CWW'(2))         w_clamp = CWW'(2);
    else if (w_ext > CWW'(MAX_WIDTH))     w_clamp = CWW'(MAX_WIDTH);
    else                                  w_clamp = w_ext;
    priority if (h_ext < RWW'(2))         h_clamp = RWW'(2);
    else if (h_ext > RWW'(MAX_HEIGHT))    h_clamp = RWW'(MAX_HEIGHT);
    else                                  h_clamp = h_ext;
  end

  // Handshake control
  logic     s1_v_q;
  pend_t    pend_q, pend_d;
  logic     ov_q;
  logic     emit, last, retire, load;

  assign last       = !pend_q.corner && !pend_q.vert && !pend_q.horiz;
  assign emit       = s1_v_q && (!ov_q || !out_stall_i);
  assign retire     = emit && last;
  assign in_stall_o = s1_v_q && !retire;
  assign load       = in_valid_i && !in_stall_o;

  // Source position
  logic [CW-1:0]  col_q;
  logic [RW-1:0]  row_q;
  logic [CWW-1:0] col_inc;
  logic [RWW-1:0] row_inc;

  assign col_inc = CWW'(col_q) + CWW'(1);
  assign row_inc = RWW'(row_q) + RWW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_wr) begin
      col_q <= '0;
      row_q <= '0;
    end else if (load) begin
      if (col_inc >= w_clamp) begin
        col_q <= '0;
        row_q <= (row_inc >= h_clamp) ? '0 : row_inc[RW-1:0];
      end else begin
        col_q <= col_inc[CW-1:0];
      end
    end
  end

  // Previous source row; read-before-write at the same column
  rgb_t row_mem [MAX_WIDTH];
  rgb_t above_q;
  rgb_t in_pix;

  assign in_pix = rgb_t'(in_data_i);

  always_ff @(posedge clk_i) begin
    if (load) begin
      above_q      <= row_mem[col_q];
      row_mem[col_q] <= in_pix;
    end
  end

  // Work stage
  rgb_t          cur_q, left_q, s1_left_q, above_left_q;
  logic [CW-1:0] s1_col_q;
  logic [RW-1:0] s1_row_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      left_q    <= in_pix;
      cur_q     <= in_pix;
      s1_left_q <= left_q;
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
    end
    // above of this item is above-left of the next one in the row
    if (retire) begin
      above_left_q <= above_q;
    end
  end

  // Pick the next result
  rgb_t            hup, hdn, res_pix;
  logic [CW:0]     col2, col2m1;
  logic [RW:0]     row2, row2m1;
  logic [COORD_W-1:0] res_row, res_col;

  assign hup    = avg_rgb(above_left_q, above_q);
  assign hdn    = avg_rgb(s1_left_q, cur_q);
  assign col2   = {s1_col_q, 1'b0};
  assign row2   = {s1_row_q, 1'b0};
  assign col2m1 = col2 - (CW+1)'(1);
  assign row2m1 = row2 - (RW+1)'(1);

  always_comb begin
    pend_d = pend_q;
    priority if (pend_q.corner) begin
      res_pix       = avg_rgb(hup, hdn);
      res_row       = COORD_W'(row2m1);
      res_col       = COORD_W'(col2m1);
      pend_d.corner = 1'b0;
    end else if (pend_q.vert) begin
      res_pix       = avg_rgb(above_q, cur_q);
      res_row       = COORD_W'(row2m1);
      res_col       = COORD_W'(col2);
      pend_d.vert   = 1'b0;
    end else if (pend_q.horiz) begin
      res_pix       = hdn;
      res_row       = COORD_W'(row2);
      res_col       = COORD_W'(col2m1);
      pend_d.horiz  = 1'b0;
    end else begin
      res_pix       = cur_q;
      res_row       = COORD_W'(row2);
      res_col       = COORD_W'(col2);
      pend_d.copy   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      pend_q <= '0;
    end else if (load) begin
      s1_v_q        <= 1'b1;
      pend_q.corner <= (row_q != '0) && (col_q != '0);
      pend_q.vert   <= (row_q != '0);
      pend_q.horiz  <= (col_q != '0);
      pend_q.copy   <= 1'b1;
    end else if (emit) begin
      s1_v_q <= !last;
      pend_q <= pend_d;
    end
  end

  // Output register
  pix_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (emit) begin
      ov_q <= 1'b1;
    end else if (!out_stall_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.out_row   <= res_row;
      out_q.out_col   <= res_col;
      out_q.red_out   <= res_pix.red;
      out_q.green_out <= res_pix.green;
      out_q.blue_out  <= res_pix.blue;
      out_q.run_end   <= last;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  // Checks
  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!s1_v_q || retire))
    else $error("work stage loaded while still busy");

  a_copy_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> pend_q.copy)
    else $error("busy work stage has no copy result pending");

  a_load_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> s1_v_q)
    else $error("accepted pixel did not reach work stage");

  a_end_is_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.run_end) |->
      (!out_data_o.out_row[0] && !out_data_o.out_col[0]))
    else $error("last result of a pixel is not its copy");

endmodule

>>> dv/upscale_2x_averaging_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// upscale_2x_averaging_core_tb
// Self-checking bench for the 2x averaging upscaler. Source pixels are
// streamed through a valid/stall driver and every output pixel is compared
// against a cycle-free predictor that keeps its own copy of the previous
// source row. Frame sizes, register rewrites mid-frame, clamped sizes and
// several source/sink idling profiles are covered.
// ----------------------------------------------------------------------------
module upscale_2x_averaging_core_tb;
  import ups2x_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  pix_in_t           in_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  pix_out_t          out_data_o;

  pix_in_t     pixel_feed_q[$];
  pix_out_t    upscaled_q[$];
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned err_count = 0;

  // predictor state
  rgb_t             prev_row[MAX_WIDTH_DEF];
  rgb_t             left_px;
  rgb_t             above_left_px;
  int unsigned      src_r;
  int unsigned      src_c;
  logic [CFG_W-1:0] cfg_width = WIDTH_RST;
  logic [CFG_W-1:0] cfg_height = HEIGHT_RST;

  upscale_2x_averaging_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic logic [CHAN_W-1:0] chan_mean(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
    logic [CHAN_W:0] total;
    total = (CHAN_W+1)'(a) + (CHAN_W+1)'(b);
    return total[CHAN_W:1];
  endfunction

  function automatic rgb_t pixel_mean(input rgb_t a, input rgb_t b);
    rgb_t m;
    m.red   = chan_mean(a.red, b.red);
    m.green = chan_mean(a.green, b.green);
    m.blue  = chan_mean(a.blue, b.blue);
    return m;
  endfunction

  function void push_upscaled(input int unsigned row, input int unsigned col, input rgb_t v,
                              input logic last);
    pix_out_t o;
    o.out_row   = COORD_W'(row);
    o.out_col   = COORD_W'(col);
    o.red_out   = v.red;
    o.green_out = v.green;
    o.blue_out  = v.blue;
    o.run_end   = last;
    upscaled_q.push_back(o);
  endfunction

  // Expand one accepted source pixel into its output pixels, in emission order.
  function void expand_pixel(input pix_in_t px);
    rgb_t        cur;
    rgb_t        above;
    int unsigned w;
    int unsigned h;
    w = clamp_dim(cfg_width, MAX_WIDTH_DEF);
    h = clamp_dim(cfg_height, MAX_HEIGHT_DEF);
    cur = {px.red_in, px.green_in, px.blue_in};
    above = '0;
    if (src_r > 0) above = prev_row[src_c];
    if (src_r > 0 && src_c > 0)
      push_upscaled(2*src_r - 1, 2*src_c - 1,
                    pixel_mean(pixel_mean(above_left_px, above), pixel_mean(left_px, cur)),
                    1'b0);
    if (src_r > 0) push_upscaled(2*src_r - 1, 2*src_c, pixel_mean(above, cur), 1'b0);
    if (src_c > 0) push_upscaled(2*src_r, 2*src_c - 1, pixel_mean(left_px, cur), 1'b0);
    push_upscaled(2*src_r, 2*src_c, cur, 1'b1);
    prev_row[src_c] = cur;
    above_left_px = above;
    left_px = cur;
    if (src_c + 1 >= w) begin
      src_c = 0;
      src_r = (src_r + 1 >= h) ? 0 : src_r + 1;
      left_px = '0;
      above_left_px = '0;
    end else begin
      src_c = src_c + 1;
    end
  endfunction

  // source side: advance on acceptance or when idle
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (pixel_feed_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pixel_feed_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < sink_stall_pct);
  end

  always @(posedge clk_i) begin : monitor
    pix_out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) expand_pixel(in_data_i);
      if (out_valid_o && !out_stall_i) begin
        if (upscaled_q.size() == 0) begin
          $display("%0t: unexpected output transaction, got %h", $time, out_data_o);
          err_count++;
        end else begin
          want = upscaled_q.pop_front();
          if (out_data_o.out_row !== want.out_row || out_data_o.out_col !== want.out_col ||
              out_data_o.red_out !== want.red_out || out_data_o.green_out !== want.green_out ||
              out_data_o.blue_out !== want.blue_out || out_data_o.run_end !== want.run_end) begin
            $display("%0t: expected row %0d col %0d rgb %h_%h_%h end %b", $time,
                     want.out_row, want.out_col, want.red_out, want.green_out,
                     want.blue_out, want.run_end);
            $display("%0t: actual   row %0d col %0d rgb %h_%h_%h end %b", $time,
                     out_data_o.out_row, out_data_o.out_col, out_data_o.red_out,
                     out_data_o.green_out, out_data_o.blue_out, out_data_o.run_end);
            err_count++;
          end
        end
      end
    end
  end

  task automatic cfg_write(input reg_idx_e idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) cfg_width = val;
    else cfg_height = val;
    // any write restarts the frame
    src_r = 0;
    src_c = 0;
    left_px = '0;
    above_left_px = '0;
  endtask

  task automatic cfg_check(input reg_idx_e idx, input logic [CFG_W-1:0] want);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[CFG_W-1:0] !== want) begin
      $display("%0t: register %s read expected %0d, actual %0d", $time, idx.name(), want,
               prdata[CFG_W-1:0]);
      err_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_dims(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    if ($urandom_range(1)) begin
      cfg_write(REG_IMAGE_WIDTH, w);
      cfg_write(REG_IMAGE_HEIGHT, h);
    end else begin
      cfg_write(REG_IMAGE_HEIGHT, h);
      cfg_write(REG_IMAGE_WIDTH, w);
    end
  endtask

  task automatic set_idling(input int unsigned profile);
    case (profile % 4)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 56; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 56; end
      default: begin src_idle_pct = 17; sink_stall_pct = 17; end
    endcase
  endtask

  // hold until every queued pixel is in and every output pixel is out
  task automatic drain();
    while (pixel_feed_q.size() != 0 || in_valid_i || upscaled_q.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  function automatic pix_in_t make_px(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    pix_in_t p;
    p.red_in   = r;
    p.green_in = g;
    p.blue_in  = b;
    return p;
  endfunction

  task automatic queue_random(input int unsigned n);
    pix_in_t p;
    repeat (n) begin
      case ($urandom_range(9))
        0: p = '0;
        1: p = '1;
        2: p = make_px({8{1'($urandom_range(1))}}, {8{1'($urandom_range(1))}},
                       {8{1'($urandom_range(1))}});
        default: p = pix_in_t'(24'($urandom));
      endcase
      pixel_feed_q.push_back(p);
    end
  endtask

  initial begin
    int unsigned      random_items;
    int unsigned      phase;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    cfg_check(REG_IMAGE_WIDTH, WIDTH_RST);
    cfg_check(REG_IMAGE_HEIGHT, HEIGHT_RST);

    // reset sizes, start of row 0
    queue_random(3);
    drain();

    // 2x2 frames: every output kind, odd sums, bit extremes, frame wrap
    set_dims(2, 2);
    pixel_feed_q.push_back(make_px(8'h00, 8'hFF, 8'h01));
    pixel_feed_q.push_back(make_px(8'hFF, 8'h00, 8'h02));
    pixel_feed_q.push_back(make_px(8'h55, 8'hAA, 8'h80));
    pixel_feed_q.push_back(make_px(8'hAA, 8'h55, 8'h7F));
    pixel_feed_q.push_back(make_px(8'h00, 8'h00, 8'h00));
    pixel_feed_q.push_back(make_px(8'hFF, 8'hFF, 8'hFF));
    pixel_feed_q.push_back(make_px(8'hFF, 8'hFF, 8'hFF));
    pixel_feed_q.push_back(make_px(8'h01, 8'h00, 8'hFE));
    drain();

    // sizes below range clamp up to two
    cfg_write(REG_IMAGE_WIDTH, 0);
    cfg_write(REG_IMAGE_HEIGHT, 1);
    cfg_check(REG_IMAGE_WIDTH, 0);
    queue_random(4);
    drain();
    cfg_write(REG_IMAGE_WIDTH, 1);
    cfg_write(REG_IMAGE_HEIGHT, 0);
    queue_random(4);
    drain();

    // restart in the middle of a frame
    set_dims(3, 3);
    queue_random(4);
    drain();
    cfg_write(REG_IMAGE_WIDTH, 3);
    queue_random(10);
    drain();

    random_items = 0;
    phase = 0;
    while (random_items < 200) begin
      set_idling(phase);
      w = CFG_W'($urandom_range(2, 6));
      h = CFG_W'($urandom_range(2, 4));
      if ($urandom_range(7) == 0) w = CFG_W'($urandom_range(1));
      if ($urandom_range(7) == 0) h = CFG_W'($urandom_range(1));
      if ($urandom_range(3) == 0) cfg_write(REG_IMAGE_WIDTH, w);
      else set_dims(w, h);
      queue_random(clamp_dim(cfg_width, MAX_WIDTH_DEF) * clamp_dim(cfg_height, MAX_HEIGHT_DEF)
                   * $urandom_range(1, 2) + $urandom_range(0, 5));
      random_items += pixel_feed_q.size();
      drain();
      phase++;
    end

    // widest row: start of row 0 at the largest width
    set_idling(3);
    set_dims(CFG_W'(MAX_WIDTH_DEF), CFG_W'(MAX_HEIGHT_DEF + 1));
    queue_random(12);
    drain();

    // tallest frame: first rows at the largest height
    set_idling(1);
    set_dims(2, CFG_W'(MAX_HEIGHT_DEF));
    queue_random(12);
    drain();

    // all-ones sizes clamp to the maximum
    set_idling(2);
    set_dims('1, '1);
    cfg_check(REG_IMAGE_HEIGHT, '1);
    queue_random(6);
    drain();

    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("upscale_2x_averaging_core: match");
    end else begin
      $display("upscale_2x_averaging_core: mismatch");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("upscale_2x_averaging_core: mismatch");
    $finish;
  end

endmodule
